// ----- hw/rtl/bea_pkg.sv -----
package bea_pkg;

    // field widths
    localparam int W_RES   = 56;
    localparam int W_TIME  = 40;
    localparam int W_MV    = 16;
    localparam int W_CUR   = 20;
    localparam int W_AMT   = 40;
    localparam int W_MUL_A = 28;
    localparam int W_PROD  = W_MUL_A + W_CUR;

    localparam logic [W_RES-1:0]  MAX_RES  = {W_RES{1'b1}};
    localparam logic [W_TIME-1:0] MAX_TIME = {W_TIME{1'b1}};
    localparam logic [W_AMT-1:0]  MAX_CUR  = W_AMT'({W_CUR{1'b1}});

    // reset value of the supply configuration register
    localparam logic [W_MV-1:0] RST_SUPPLY = 16'd3300;

    // action codes
    localparam logic [2:0] ACT_SET     = 3'd0;
    localparam logic [2:0] ACT_DEDUCT  = 3'd1;
    localparam logic [2:0] ACT_UPDATE  = 3'd2;
    localparam logic [2:0] ACT_PUBLISH = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_DEVICE   = 2'd1;
    localparam logic [1:0] ERR_ACTIVITY = 2'd2;
    localparam logic [1:0] ERR_CURRENT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SUPPLY  = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_INITIAL = 2'd2;
    localparam logic [1:0] CFG_STEP    = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DED_RD,
        ST_DED_WR,
        ST_DV_LO,
        ST_DV_HI,
        ST_DV_SUM,
        ST_DEV_LO,
        ST_DEV_HI,
        ST_DEV_E,
        ST_DEV_UPD,
        ST_SET_END,
        ST_PUB,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_CHECK,
        CMD_DED_RD,
        CMD_DED_WR,
        CMD_DV_LO,
        CMD_DV_HI,
        CMD_DV_SUM,
        CMD_DEV_LO,
        CMD_DEV_HI,
        CMD_DEV_E,
        CMD_DEV_UPD,
        CMD_DEV_SKIP,
        CMD_SET_END,
        CMD_PUB,
        CMD_READ_RD,
        CMD_READ_OUT,
        CMD_FINISH,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] err;
        logic       depleted;
        logic       dev_active;
        logic       dev_last;
    } t_dp_status;

endpackage

// ----- hw/rtl/bea_ctrl.sv -----
module bea_ctrl
    import bea_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_cmd       o_cmd,
    output logic       o_s_tready,
    output logic       o_m_tvalid
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = CMD_NONE;
        o_s_tready  = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                // no transaction is taken while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd   = CMD_CAPTURE;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd = CMD_CHECK;
                if (i_status.err != ERR_OK) begin
                    n_state = ST_OUT;
                end else begin
                    case (i_status.action)
                        ACT_SET:     n_state = i_status.depleted ? ST_FINISH : ST_DV_LO;
                        ACT_DEDUCT:  n_state = ST_DED_RD;
                        ACT_UPDATE:  n_state = i_status.depleted ? ST_OUT : ST_DV_LO;
                        ACT_PUBLISH: n_state = ST_FINISH;
                        ACT_READ:    n_state = ST_READ_RD;
                        default:     n_state = ST_OUT;
                    endcase
                end
            end
            ST_DED_RD: begin
                o_cmd   = CMD_DED_RD;
                n_state = ST_DED_WR;
            end
            ST_DED_WR: begin
                o_cmd   = CMD_DED_WR;
                n_state = i_status.depleted ? ST_OUT : ST_DV_LO;
            end
            ST_DV_LO: begin
                o_cmd   = CMD_DV_LO;
                n_state = ST_DV_HI;
            end
            ST_DV_HI: begin
                o_cmd   = CMD_DV_HI;
                n_state = ST_DV_SUM;
            end
            ST_DV_SUM: begin
                o_cmd   = CMD_DV_SUM;
                n_state = ST_DEV_LO;
            end
            ST_DEV_LO: begin
                if (i_status.dev_active) begin
                    o_cmd   = CMD_DEV_LO;
                    n_state = ST_DEV_HI;
                end else begin
                    o_cmd   = CMD_DEV_SKIP;
                    n_state = i_status.dev_last ? ST_SET_END : ST_DEV_LO;
                end
            end
            ST_DEV_HI: begin
                o_cmd   = CMD_DEV_HI;
                n_state = ST_DEV_E;
            end
            ST_DEV_E: begin
                o_cmd   = CMD_DEV_E;
                n_state = ST_DEV_UPD;
            end
            ST_DEV_UPD: begin
                o_cmd   = CMD_DEV_UPD;
                n_state = i_status.dev_last ? ST_SET_END : ST_DEV_LO;
            end
            ST_SET_END: begin
                o_cmd   = CMD_SET_END;
                n_state = ST_PUB;
            end
            ST_PUB: begin
                o_cmd   = CMD_PUB;
                n_state = (i_status.action == ACT_SET) ? ST_FINISH : ST_OUT;
            end
            ST_READ_RD: begin
                o_cmd   = CMD_READ_RD;
                n_state = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                o_cmd   = CMD_READ_OUT;
                n_state = ST_OUT;
            end
            ST_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd       = CMD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/bea_dp.sv -----
module bea_dp
    import bea_pkg::*;
#(
    parameter int NUM_DEVICES    = 8,
    parameter int NUM_ACTIVITIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [W_RES-1:0]  i_cfg_wdata,
    input  logic [2:0]        i_action,
    input  logic [2:0]        i_device,
    input  logic [3:0]        i_activity,
    input  logic [W_AMT-1:0]  i_amount,
    input  logic [W_TIME-1:0] i_now_time,
    output t_dp_status        o_status,
    output logic [W_RES-1:0]  o_residual_energy,
    output logic              o_depleted,
    output logic              o_depleted_now,
    output logic              o_publish_now,
    output logic [1:0]        o_error_code,
    output logic [W_RES-1:0]  o_account_energy,
    output logic [W_TIME-1:0] o_account_time
);

    localparam int DEPTH = NUM_DEVICES * NUM_ACTIVITIES;
    localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    // configuration
    logic [W_MV-1:0]  r_supply;
    logic [W_RES-1:0] r_nominal;
    logic [W_RES-1:0] r_step;

    // gauge state
    logic [W_RES-1:0]  r_residual;
    logic [W_RES-1:0]  r_last_pub;
    logic [W_TIME-1:0] r_last_update;
    logic              r_depleted;

    // per device draw
    logic [W_CUR-1:0] r_cur     [NUM_DEVICES];
    logic             r_dact_en [NUM_DEVICES];
    logic [2:0]       r_dact    [NUM_DEVICES];

    // captured transaction
    logic [2:0]        r_action;
    logic [2:0]        r_dev;
    logic [3:0]        r_act;
    logic [W_AMT-1:0]  r_amount;
    logic [W_TIME-1:0] r_now;

    // per item results
    logic              r_dep_now;
    logic              r_pub_now;
    logic [1:0]        r_err;
    logic [W_RES-1:0]  r_acc_e;
    logic [W_TIME-1:0] r_acc_t;

    // settlement datapath
    logic [W_TIME-1:0] r_dt;
    logic [W_PROD-1:0] r_prod;
    logic [W_PROD-1:0] r_acc;
    logic [W_RES-1:0]  r_dv;
    logic [W_RES-1:0]  r_e;
    logic              r_under;
    logic [DW-1:0]     r_d;

    // account store
    logic [W_RES-1:0]  mem_e [DEPTH];
    logic [W_TIME-1:0] mem_t [DEPTH];
    logic              r_valid [DEPTH];
    logic [W_RES-1:0]  r_rd_e;
    logic [W_TIME-1:0] r_rd_t;
    logic              r_rd_v;

    // output register
    logic [W_RES-1:0]  r_o_res;
    logic              r_o_dep;
    logic              r_o_dep_now;
    logic              r_o_pub_now;
    logic [1:0]        r_o_err;
    logic [W_RES-1:0]  r_o_acc_e;
    logic [W_TIME-1:0] r_o_acc_t;

    logic              dev_ok;
    logic              act_neg;
    logic              act_big;
    logic [1:0]        err;
    logic [DW-1:0]     dev_idx;
    logic [10:0]       in_k_full;
    logic [10:0]       walk_k_full;
    logic [KW-1:0]     in_k;
    logic [KW-1:0]     walk_k;
    logic [KW-1:0]     rd_addr;
    logic [KW-1:0]     wr_addr;
    logic              mem_rd;
    logic              mem_wr;
    logic [W_RES-1:0]  wr_e;
    logic [W_TIME-1:0] wr_t;
    logic [W_RES-1:0]  acc_rd_e;
    logic [W_TIME-1:0] acc_rd_t;
    logic [W_RES:0]    sum_e;
    logic [W_RES:0]    sum_ded;
    logic [W_TIME:0]   sum_t;
    logic [W_MUL_A-1:0] mul_a;
    logic [W_CUR-1:0]  mul_b;
    logic [W_PROD+W_MUL_A-1:0] e_full;
    logic [W_RES-1:0]  ded_res;
    logic [W_RES-1:0]  end_res;
    logic [W_RES-1:0]  pub_drop;

    // request checks
    assign dev_ok    = {4'b0, r_dev} < 7'(NUM_DEVICES);
    assign act_neg   = r_act[3];
    assign act_big   = !act_neg && ({2'b0, r_act[2:0]} >= 5'(NUM_ACTIVITIES));
    assign dev_idx   = DW'({4'b0, r_dev});

    always_comb begin
        err = ERR_OK;
        if ((r_action == ACT_SET || r_action == ACT_DEDUCT || r_action == ACT_READ)
            && !dev_ok) begin
            err = ERR_DEVICE;
        end else if (r_action == ACT_SET) begin
            if (act_big) begin
                err = ERR_ACTIVITY;
            end else if ((act_neg && r_amount != '0) || r_amount > MAX_CUR) begin
                err = ERR_CURRENT;
            end
        end else if (r_action == ACT_DEDUCT || r_action == ACT_READ) begin
            if (act_neg || act_big) begin
                err = ERR_ACTIVITY;
            end
        end
    end

    // account indexes
    assign in_k_full   = 11'(r_dev) * 11'(NUM_ACTIVITIES) + 11'(r_act[2:0]);
    assign walk_k_full = 11'(r_d) * 11'(NUM_ACTIVITIES) + 11'(r_dact[r_d]);
    assign in_k        = in_k_full[KW-1:0];
    assign walk_k      = walk_k_full[KW-1:0];

    assign o_status.action     = r_action;
    assign o_status.err        = err;
    assign o_status.depleted   = r_depleted;
    assign o_status.dev_active = r_dact_en[r_d];
    assign o_status.dev_last   = (r_d == DW'(NUM_DEVICES - 1));

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            CMD_DV_LO: begin
                mul_a = W_MUL_A'(r_supply);
                mul_b = r_dt[W_CUR-1:0];
            end
            CMD_DV_HI: begin
                mul_a = W_MUL_A'(r_supply);
                mul_b = r_dt[W_TIME-1:W_CUR];
            end
            CMD_DEV_LO: begin
                mul_a = r_dv[W_MUL_A-1:0];
                mul_b = r_cur[r_d];
            end
            CMD_DEV_HI: begin
                mul_a = r_dv[W_RES-1:W_MUL_A];
                mul_b = r_cur[r_d];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // account read-modify-write values
    assign acc_rd_e = r_rd_v ? r_rd_e : '0;
    assign acc_rd_t = r_rd_v ? r_rd_t : '0;
    assign sum_e    = {1'b0, acc_rd_e} + {1'b0, r_e};
    assign sum_ded  = {1'b0, acc_rd_e} + (W_RES + 1)'(r_amount);
    assign sum_t    = {1'b0, acc_rd_t} + {1'b0, r_dt};

    always_comb begin
        mem_rd  = (i_cmd == CMD_DED_RD) || (i_cmd == CMD_READ_RD) || (i_cmd == CMD_DEV_LO);
        rd_addr = (i_cmd == CMD_DEV_LO) ? walk_k : in_k;
        mem_wr  = 1'b0;
        wr_addr = in_k;
        wr_e    = sum_ded[W_RES] ? MAX_RES : sum_ded[W_RES-1:0];
        wr_t    = acc_rd_t;
        if (i_cmd == CMD_DED_WR) begin
            mem_wr = 1'b1;
        end else if (i_cmd == CMD_DEV_UPD) begin
            mem_wr  = (r_e != '0) && (r_under || r_residual != '0);
            wr_addr = walk_k;
            wr_e    = sum_e[W_RES] ? MAX_RES : sum_e[W_RES-1:0];
            wr_t    = sum_t[W_TIME] ? MAX_TIME : sum_t[W_TIME-1:0];
        end
    end

    // account store memory
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_e[wr_addr] <= wr_e;
            mem_t[wr_addr] <= wr_t;
        end
        if (mem_rd) begin
            r_rd_e <= mem_e[rd_addr];
            r_rd_t <= mem_t[rd_addr];
        end
    end

    // written flags of the account store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_v <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (mem_rd) begin
                r_rd_v <= r_valid[rd_addr];
            end
        end
    end

    // energy of one device and residual after a deduct
    assign e_full  = (W_PROD + W_MUL_A)'(r_acc) + {r_prod, {W_MUL_A{1'b0}}};
    assign ded_res = (r_amount > W_AMT'(0) && W_RES'(r_amount) > r_residual)
                     ? '0 : r_residual - W_RES'(r_amount);
    assign end_res = r_under ? '0 : r_residual;
    assign pub_drop = r_last_pub - r_residual;

    // multiplier and settlement registers
    always_ff @(posedge i_clk) begin
        r_prod <= W_PROD'(mul_a) * W_PROD'(mul_b);
        case (i_cmd)
            CMD_CHECK:  r_dt <= (r_now >= r_last_update) ? r_now - r_last_update : '0;
            CMD_DV_HI:  r_acc <= r_prod;
            CMD_DV_SUM: r_dv <= W_RES'(r_acc) + {r_prod[W_RES-W_CUR-1:0], {W_CUR{1'b0}}};
            CMD_DEV_HI: r_acc <= r_prod;
            CMD_DEV_E:  r_e <= (e_full[W_PROD+W_MUL_A-1:W_RES] != '0)
                               ? MAX_RES : e_full[W_RES-1:0];
            default: begin
            end
        endcase
    end

    // captured fields
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_CAPTURE) begin
            r_dev    <= i_device;
            r_act    <= i_activity;
            r_amount <= i_amount;
            r_now    <= i_now_time;
        end
    end

    // device draw table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DEVICES; i++) begin
                r_dact_en[i] <= 1'b0;
            end
        end else if (i_cmd == CMD_FINISH && r_action == ACT_SET) begin
            r_dact_en[dev_idx] <= !act_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_FINISH && r_action == ACT_SET) begin
            r_cur[dev_idx]  <= r_amount[W_CUR-1:0];
            r_dact[dev_idx] <= r_act[2:0];
        end
    end

    // control and gauge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply      <= RST_SUPPLY;
            r_nominal     <= MAX_RES;
            r_step        <= MAX_RES;
            r_residual    <= MAX_RES;
            r_last_pub    <= MAX_RES;
            r_last_update <= '0;
            r_depleted    <= 1'b0;
            r_action      <= ACT_SET;
            r_under       <= 1'b0;
            r_d           <= '0;
            r_dep_now     <= 1'b0;
            r_pub_now     <= 1'b0;
            r_err         <= ERR_OK;
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SUPPLY:  r_supply <= i_cfg_wdata[W_MV-1:0];
                    CFG_NOMINAL: r_nominal <= i_cfg_wdata;
                    CFG_INITIAL: begin
                        r_residual <= i_cfg_wdata;
                        r_last_pub <= i_cfg_wdata;
                        r_depleted <= 1'b0;
                    end
                    CFG_STEP:    r_step <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            case (i_cmd)
                CMD_CAPTURE: begin
                    r_action  <= i_action;
                    r_dep_now <= 1'b0;
                    r_pub_now <= 1'b0;
                end
                CMD_CHECK: r_err <= err;
                CMD_DED_WR: begin
                    r_residual <= (ded_res > r_nominal) ? r_nominal : ded_res;
                end
                CMD_DV_LO: r_under <= 1'b0;
                CMD_DV_SUM: r_d <= '0;
                CMD_DEV_SKIP: begin
                    if (r_d != DW'(NUM_DEVICES - 1)) begin
                        r_d <= r_d + DW'(1);
                    end
                end
                CMD_DEV_UPD: begin
                    if (r_e != '0 && !r_under) begin
                        if (r_e > r_residual) begin
                            r_under    <= 1'b1;
                            r_residual <= '0;
                        end else begin
                            r_residual <= r_residual - r_e;
                        end
                    end
                    if (r_d != DW'(NUM_DEVICES - 1)) begin
                        r_d <= r_d + DW'(1);
                    end
                end
                CMD_SET_END: begin
                    r_residual    <= (end_res > r_nominal) ? r_nominal : end_res;
                    r_last_update <= r_now;
                end
                CMD_PUB: begin
                    if (r_residual == '0) begin
                        r_depleted <= 1'b1;
                        r_dep_now  <= 1'b1;
                    end else if (r_last_pub >= r_residual && pub_drop >= r_step) begin
                        r_pub_now  <= 1'b1;
                        r_last_pub <= r_residual;
                    end
                end
                CMD_FINISH: begin
                    if (r_action == ACT_PUBLISH) begin
                        r_last_pub <= r_residual;
                        r_pub_now  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // read account result
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_CAPTURE) begin
            r_acc_e <= '0;
            r_acc_t <= '0;
        end else if (i_cmd == CMD_READ_OUT) begin
            r_acc_e <= acc_rd_e;
            r_acc_t <= acc_rd_t;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_OUT) begin
            r_o_res     <= r_residual;
            r_o_dep     <= r_depleted;
            r_o_dep_now <= r_dep_now;
            r_o_pub_now <= r_pub_now;
            r_o_err     <= r_err;
            r_o_acc_e   <= r_acc_e;
            r_o_acc_t   <= r_acc_t;
        end
    end

    assign o_residual_energy = r_o_res;
    assign o_depleted        = r_o_dep;
    assign o_depleted_now    = r_o_dep_now;
    assign o_publish_now     = r_o_pub_now;
    assign o_error_code      = r_o_err;
    assign o_account_energy  = r_o_acc_e;
    assign o_account_time    = r_o_acc_t;

endmodule

// ----- hw/rtl/battery_energy_accountant.sv -----
// Linear battery gauge that settles per-device energy (current x supply voltage x elapsed
// ticks) into saturating activity accounts and the residual capacity, one event at a time.
// An event is captured in IDLE and decoded in CHECK; a settlement then forms voltage x
// elapsed time (DV_LO, DV_HI, DV_SUM), runs DEV_LO, DEV_HI, DEV_E and DEV_UPD for each
// device with an activity set and a skip in DEV_LO for each idle device, and closes in
// SET_END and PUB; a deduct adds DED_RD and DED_WR and a device set adds FINISH, while a
// read passes READ_RD and READ_WAIT after decode with no settlement. The result is then
// loaded into the output register in ST_OUT, waiting while the previous result is still
// held. The single shared 28 x 20 multiplier forms each device's energy in two passes,
// and the account memory's read-modify-write uses its one read and one write port. The
// store starts cleared through per-entry written flags, so no clearing pass follows reset.
module battery_energy_accountant
    import bea_pkg::*;
#(
    parameter int NUM_DEVICES    = 8,
    parameter int NUM_ACTIVITIES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [W_RES-1:0]   i_cfg_wdata,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // device[2:0], activity[6:3], amount[46:7], now_time[86:47], zero fill
    input  logic [87:0]        i_s_tdata,
    // action[2:0]
    input  logic [2:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // residual_energy[55:0], depleted[56], depleted_now[57], publish_now[58],
    // error_code[60:59], account_energy[116:61], account_time[156:117], zero fill
    output logic [159:0]       o_m_tdata
);

    t_cmd              cmd;
    t_dp_status        status;
    logic [W_RES-1:0]  res_e;
    logic              dep;
    logic              dep_now;
    logic              pub_now;
    logic [1:0]        err_code;
    logic [W_RES-1:0]  acc_e;
    logic [W_TIME-1:0] acc_t;

    // sequencer
    bea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    // gauge datapath and account store
    bea_dp #(
        .NUM_DEVICES    (NUM_DEVICES),
        .NUM_ACTIVITIES (NUM_ACTIVITIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_action          (i_s_tuser),
        .i_device          (i_s_tdata[2:0]),
        .i_activity        (i_s_tdata[6:3]),
        .i_amount          (i_s_tdata[46:7]),
        .i_now_time        (i_s_tdata[86:47]),
        .o_status          (status),
        .o_residual_energy (res_e),
        .o_depleted        (dep),
        .o_depleted_now    (dep_now),
        .o_publish_now     (pub_now),
        .o_error_code      (err_code),
        .o_account_energy  (acc_e),
        .o_account_time    (acc_t)
    );

    // result packing
    assign o_m_tdata = {3'b0, acc_t, acc_e, err_code, pub_now, dep_now, dep, res_e};

endmodule

// ----- bench/battery_energy_accountant_tb.sv -----
module battery_energy_accountant_tb
    import bea_pkg::*;
();

    localparam int N_DEV = 8;
    localparam int N_ACT = 8;
    localparam logic [55:0] M56 = {56{1'b1}};
    localparam logic [39:0] M40 = {40{1'b1}};

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  device;
        logic [3:0]  activity;
        logic [39:0] amount;
        logic [39:0] now_time;
    } t_event;

    // highest field first so that the packing matches the result bus
    typedef struct packed {
        logic [39:0] account_time;
        logic [55:0] account_energy;
        logic [1:0]  error_code;
        logic        publish_now;
        logic        depleted_now;
        logic        depleted;
        logic [55:0] residual_energy;
    } t_gauge;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [1:0]   i_cfg_index;
    logic [55:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [87:0]  i_s_tdata;
    logic [2:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [159:0] o_m_tdata;

    battery_energy_accountant u_top (.*);

    // gauge model state
    logic [15:0] mv_supply;
    logic [55:0] nom_energy, pub_step;
    logic [55:0] res_energy, last_pub;
    logic [39:0] last_tick;
    logic        flat;
    logic [19:0] dev_cur [N_DEV];
    logic [3:0]  dev_act [N_DEV];
    logic [55:0] acc_energy [N_DEV*N_ACT];
    logic [39:0] acc_time [N_DEV*N_ACT];

    t_event pending_events[$];
    t_gauge expected_gauge[$];
    int     mismatches;
    int     send_idle, recv_stall;
    logic   hold_send;
    logic [39:0] clock_ticks;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [55:0] sat56(logic [55:0] a, logic [55:0] b);
        logic [56:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[56] ? M56 : s[55:0];
    endfunction

    function automatic logic [39:0] sat40(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? M40 : s[39:0];
    endfunction

    // settle energy drawn since the last update
    task automatic settle_energy(input logic [39:0] now, inout logic dn, inout logic pn);
        logic [39:0]  dt;
        logic [127:0] dv, e;
        logic [55:0]  rem;
        logic         under;
        int           k;
        if (flat) return;
        dt = (now >= last_tick) ? now - last_tick : 40'd0;
        dv = 128'(mv_supply) * 128'(dt);
        rem = res_energy;
        under = 1'b0;
        for (int d = 0; d < N_DEV; d++) begin
            if (dev_act[d][3]) continue;
            e = 128'(dev_cur[d]) * dv;
            if (e > 128'(M56)) e = 128'(M56);
            if (e == 0) continue;
            if (under || rem != 0) begin
                k = d * N_ACT + int'(dev_act[d]);
                acc_energy[k] = sat56(acc_energy[k], e[55:0]);
                acc_time[k] = sat40(acc_time[k], dt);
            end
            if (!under) begin
                if (e[55:0] > rem) begin
                    under = 1'b1;
                    rem = '0;
                end else begin
                    rem = rem - e[55:0];
                end
            end
        end
        last_tick = now;
        res_energy = under ? 56'd0 : rem;
        if (res_energy > nom_energy) res_energy = nom_energy;
        if (res_energy == 0) begin
            flat = 1'b1;
            dn = 1'b1;
        end else if (last_pub >= res_energy && last_pub - res_energy >= pub_step) begin
            pn = 1'b1;
            last_pub = res_energy;
        end
    endtask

    task automatic predict_event(input t_event ev);
        t_gauge g;
        int     k;
        logic   neg;
        g = '0;
        neg = ev.activity[3];
        k = int'(ev.device) * N_ACT + int'(ev.activity[2:0]);
        case (ev.action)
            ACT_SET: begin
                if (ev.amount > 40'hFFFFF || (neg && ev.amount != 0)) begin
                    g.error_code = ERR_CURRENT;
                end else begin
                    settle_energy(ev.now_time, g.depleted_now, g.publish_now);
                    dev_cur[ev.device] = ev.amount[19:0];
                    dev_act[ev.device] = neg ? 4'hF : ev.activity;
                end
            end
            ACT_DEDUCT: begin
                if (neg) begin
                    g.error_code = ERR_ACTIVITY;
                end else begin
                    acc_energy[k] = sat56(acc_energy[k], 56'(ev.amount));
                    res_energy = (56'(ev.amount) > res_energy) ? 56'd0
                               : res_energy - 56'(ev.amount);
                    if (res_energy > nom_energy) res_energy = nom_energy;
                    settle_energy(ev.now_time, g.depleted_now, g.publish_now);
                end
            end
            ACT_UPDATE: settle_energy(ev.now_time, g.depleted_now, g.publish_now);
            ACT_PUBLISH: begin
                last_pub = res_energy;
                g.publish_now = 1'b1;
            end
            ACT_READ: begin
                if (neg) begin
                    g.error_code = ERR_ACTIVITY;
                end else begin
                    g.account_energy = acc_energy[k];
                    g.account_time = acc_time[k];
                end
            end
            default: ;
        endcase
        g.residual_energy = res_energy;
        g.depleted = flat;
        expected_gauge.push_back(g);
    endtask

    // config write while idle, mirrored into the model
    task automatic write_reg(input logic [1:0] idx, input logic [55:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SUPPLY:  mv_supply = val[15:0];
            CFG_NOMINAL: nom_energy = val;
            CFG_INITIAL: begin
                res_energy = val;
                last_pub = val;
                flat = 1'b0;
            end
            CFG_STEP:    pub_step = val;
            default: ;
        endcase
    endtask

    task automatic queue_event(input logic [2:0] a, input logic [2:0] d, input logic [3:0] ac,
                               input logic [39:0] amt, input logic [39:0] t);
        t_event ev;
        ev.action = a;
        ev.device = d;
        ev.activity = ac;
        ev.amount = amt;
        ev.now_time = t;
        pending_events.push_back(ev);
    endtask

    task automatic drain();
        while (pending_events.size() != 0 || expected_gauge.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // re-arm a depleted battery mid-phase once idle
    task automatic write_reg_refill();
        if (flat) begin
            drain();
            write_reg(CFG_INITIAL, 56'($urandom_range(1 << 20, 1 << 30)));
        end
    endtask

    // random event, mostly well-formed with advancing time
    task automatic queue_random(input int cur_bits);
        logic [2:0]  a;
        logic [3:0]  ac;
        logic [39:0] amt;
        int          r;
        r = $urandom_range(0, 99);
        a = (r < 30) ? ACT_SET : (r < 45) ? ACT_DEDUCT : (r < 70) ? ACT_UPDATE
          : (r < 78) ? ACT_PUBLISH : (r < 95) ? ACT_READ : 3'($urandom_range(5, 7));
        ac = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
        amt = 40'($urandom_range(0, (1 << cur_bits) - 1));
        if ($urandom_range(0, 19) == 0) amt = {8'($urandom), 32'($urandom)};
        if ($urandom_range(0, 29) == 0) clock_ticks = clock_ticks - 40'($urandom_range(0, 50));
        else clock_ticks = clock_ticks + 40'($urandom_range(0, 40));
        if ($urandom_range(0, 99) == 0) clock_ticks = {8'($urandom), 32'($urandom)};
        queue_event(a, 3'($urandom), ac, amt, clock_ticks);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                predict_event(pending_events.pop_front());
            end
            if (pending_events.size() != 0 && !hold_send
                && $urandom_range(0, 99) >= send_idle) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser <= pending_events[0].action;
                i_s_tdata <= {1'b0, pending_events[0].now_time, pending_events[0].amount,
                              pending_events[0].activity, pending_events[0].device};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_gauge got, exp_g;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[156:0];
                if (expected_gauge.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %h", got);
                end else begin
                    exp_g = expected_gauge.pop_front();
                    if (got !== exp_g) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp res=%h dep=%b dn=%b pub=%b err=%0d ae=%h at=%h",
                                exp_g.residual_energy, exp_g.depleted, exp_g.depleted_now,
                                exp_g.publish_now, exp_g.error_code, exp_g.account_energy,
                                exp_g.account_time);
                            $display("          got res=%h dep=%b dn=%b pub=%b err=%0d ae=%h at=%h",
                                got.residual_energy, got.depleted, got.depleted_now,
                                got.publish_now, got.error_code, got.account_energy,
                                got.account_time);
                        end
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_SUPPLY;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_send = 1'b0;
        mismatches = 0;
        clock_ticks = '0;
        mv_supply = RST_SUPPLY;
        nom_energy = M56;
        pub_step = M56;
        res_energy = M56;
        last_pub = M56;
        last_tick = '0;
        flat = 1'b0;
        for (int i = 0; i < N_DEV; i++) begin
            dev_cur[i] = '0;
            dev_act[i] = 4'hF;
        end
        for (int i = 0; i < N_DEV * N_ACT; i++) begin
            acc_energy[i] = '0;
            acc_time[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, each action, error paths, depletion
        queue_event(ACT_READ, 3'd0, 4'd0, '0, '0);
        queue_event(ACT_SET, 3'd0, 4'd0, 40'hFFFFF, 40'd0);
        queue_event(ACT_SET, 3'd7, 4'd7, 40'd1, 40'd5);
        queue_event(ACT_SET, 3'd1, 4'd8, 40'd3, 40'd6);
        queue_event(ACT_SET, 3'd2, 4'hF, 40'd5, 40'd6);
        queue_event(ACT_SET, 3'd2, 4'hF, 40'd0, 40'd7);
        queue_event(ACT_SET, 3'd3, 4'd2, 40'h100000, 40'd7);
        queue_event(ACT_SET, 3'd3, 4'd2, M40, 40'd7);
        queue_event(ACT_UPDATE, 3'd0, 4'd0, '0, M40);
        queue_event(ACT_UPDATE, 3'd0, 4'd0, '0, 40'd100);
        queue_event(ACT_DEDUCT, 3'd4, 4'hF, 40'd9, 40'd100);
        queue_event(ACT_DEDUCT, 3'd4, 4'd5, M40, 40'd101);
        queue_event(ACT_PUBLISH, 3'd0, 4'd0, '0, '0);
        queue_event(ACT_READ, 3'd0, 4'd0, '0, '0);
        queue_event(ACT_READ, 3'd7, 4'd7, '0, '0);
        queue_event(ACT_READ, 3'd4, 4'd5, '0, '0);
        queue_event(ACT_READ, 3'd4, 4'h9, '0, '0);
        queue_event(3'd5, 3'd0, 4'd0, '0, '0);
        queue_event(3'd7, 3'd7, 4'hF, M40, M40);
        drain();

        // small battery: depletion and publish steps
        write_reg(CFG_SUPPLY, 56'd1);
        write_reg(CFG_NOMINAL, 56'd100000);
        write_reg(CFG_INITIAL, 56'd60000);
        write_reg(CFG_STEP, 56'd500);
        clock_ticks = 40'd1000;
        queue_event(ACT_SET, 3'd0, 4'd1, 40'd0, 40'd1000);
        queue_event(ACT_SET, 3'd1, 4'd1, 40'd10, 40'd1000);
        queue_event(ACT_UPDATE, 3'd0, 4'd0, '0, 40'd1100);
        queue_event(ACT_DEDUCT, 3'd1, 4'd1, 40'd59000, 40'd1100);
        queue_event(ACT_UPDATE, 3'd0, 4'd0, '0, 40'd1300);
        queue_event(ACT_UPDATE, 3'd0, 4'd0, '0, 40'd1400);
        queue_event(ACT_READ, 3'd1, 4'd1, '0, '0);
        drain();

        // random phases across register settings and idling profiles
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                3: begin send_idle = 7;  recv_stall = 7;  end
                4: begin send_idle = 0;  recv_stall = 0;  end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            write_reg(CFG_SUPPLY, (ph == 4) ? 56'hFFFF : (ph == 2) ? 56'd0
                                                         : 56'($urandom_range(1, 5000)));
            write_reg(CFG_NOMINAL, (ph == 0) ? M56 : (ph == 5) ? 56'd1
                                                   : 56'($urandom_range(1 << 20, 1 << 30)));
            write_reg(CFG_INITIAL, (ph == 3) ? 56'd0 : (ph == 4) ? M56
                                                   : 56'($urandom_range(1 << 18, 1 << 31)));
            write_reg(CFG_STEP, (ph == 1) ? 56'd0 : 56'($urandom_range(1000, 1 << 24)));
            for (int n = 0; n < 100; n++) begin
                queue_random((ph == 4) ? 20 : 8);
                if (n % 25 == 24) write_reg_refill();
            end
            if (ph == 3) begin
                while (pending_events.size() > 50) @(posedge i_clk);
                hold_send = 1'b1;
                while (expected_gauge.size() != 0 || i_s_tvalid) @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain();
        end

        if (mismatches == 0 && expected_gauge.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bea_pkg.sv
hw/rtl/bea_ctrl.sv
hw/rtl/bea_dp.sv
hw/rtl/battery_energy_accountant.sv
bench/battery_energy_accountant_tb.sv
